[rtl/core/lru_page_replacement_defines.svh]
// Assertion macros shared by the LRU page replacement RTL.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru page replacement: same-cycle check failed");
// next-cycle implication
`define LRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru page replacement: next-cycle check failed");
`else
`define LRP_ASSERT_NOW(lbl, ante, cons)
`define LRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/lrp_pkg.sv]
package lrp_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int CFG_BITS       = 4;
    localparam int COUNT_BITS     = 32;

    localparam logic [CFG_BITS-1:0] LIMIT_RESET = CFG_BITS'(3);

    // request from the pipeline into the frame store and the counters
    typedef struct packed {
        logic go;     // an access is processed this cycle
        logic clear;  // empty frames and counts before the access
    } t_frm_req;

    // outcome of one lookup
    typedef struct packed {
        logic hit;
        logic evict;
    } t_frm_stat;

endpackage

[rtl/core/lrp_frames.sv]
`include "lru_page_replacement_defines.svh"

module lrp_frames #(
    parameter int MAX_FRAMES = lrp_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrp_pkg::PAGE_BITS_DEF,
    parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrp_pkg::t_frm_req     i_req,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [CNT_W-1:0]      i_limit,
    output lrp_pkg::t_frm_stat    o_stat,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [PAGE_BITS-1:0]  o_evict_page,
    output logic [CNT_W-1:0]      o_count
);
    import lrp_pkg::*;

    logic [PAGE_BITS-1:0] r_page [MAX_FRAMES];
    logic [SLOT_W-1:0]    r_rank [MAX_FRAMES];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      cnt_m1;
    logic [MAX_FRAMES-1:0] occ;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] victim;
    logic [MAX_FRAMES-1:0] age;
    logic [SLOT_W-1:0]     hit_slot;
    logic [SLOT_W-1:0]     vic_slot;
    logic [SLOT_W-1:0]     hit_rank;
    logic [SLOT_W-1:0]     ref_rank;
    logic [SLOT_W-1:0]     slot;
    logic [PAGE_BITS-1:0]  vic_page;
    logic                  hit;
    logic                  fill;
    logic                  evict;

    assign cnt    = i_req.clear ? '0 : r_count;
    assign cnt_m1 = cnt - CNT_W'(1);

    // occupied ranks form a permutation of 0..cnt-1, so the victim is unique
    always_comb begin
        hit_slot = '0;
        vic_slot = '0;
        hit_rank = '0;
        vic_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            occ[i]    = CNT_W'(i) < cnt;
            match[i]  = occ[i] && (r_page[i] == i_page);
            victim[i] = occ[i] && (r_rank[i] == cnt_m1[SLOT_W-1:0]);
            if (match[i]) begin
                hit_slot = hit_slot | SLOT_W'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (victim[i]) begin
                vic_slot = vic_slot | SLOT_W'(i);
                vic_page = vic_page | r_page[i];
            end
        end
    end

    assign hit   = |match;
    assign fill  = !hit && (cnt < i_limit);
    assign evict = !hit && !fill;

    always_comb begin
        priority if (hit) begin
            slot = hit_slot;
        end else if (fill) begin
            slot = cnt[SLOT_W-1:0];
        end else begin
            slot = vic_slot;
        end
    end

    assign ref_rank = hit ? hit_rank : cnt_m1[SLOT_W-1:0];

    // frames more recent than the touched one age by one; a fill ages them all
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            age[i] = occ[i] && (SLOT_W'(i) != slot) && (fill || (r_rank[i] < ref_rank));
        end
    end

    assign n_count = fill ? cnt + CNT_W'(1) : cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_req.go) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (SLOT_W'(i) == slot) begin
                    r_rank[i] <= '0;
                    if (!hit) begin
                        r_page[i] <= i_page;
                    end
                end else if (age[i]) begin
                    r_rank[i] <= r_rank[i] + SLOT_W'(1);
                end
            end
        end
    end

    assign o_stat.hit   = hit;
    assign o_stat.evict = evict;
    assign o_slot       = slot;
    assign o_evict_page = evict ? vic_page : '0;
    assign o_count      = n_count;

    `LRP_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(MAX_FRAMES))
    `LRP_ASSERT_NOW(a_match_one, i_req.go && hit, $onehot(match))
    `LRP_ASSERT_NOW(a_victim_one, i_req.go && evict, $onehot(victim))
    `LRP_ASSERT_NEXT(a_fill_grows, i_req.go && fill, r_count != '0)

endmodule

[rtl/core/lrp_counters.sv]
module lrp_counters (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lrp_pkg::t_frm_req              i_req,
    input  logic                           i_hit,
    output logic [lrp_pkg::COUNT_BITS-1:0] o_fault_total,
    output logic [lrp_pkg::COUNT_BITS-1:0] o_hit_total
);
    import lrp_pkg::*;

    logic [COUNT_BITS-1:0] r_fault;
    logic [COUNT_BITS-1:0] r_hit;
    logic [COUNT_BITS-1:0] n_fault;
    logic [COUNT_BITS-1:0] n_hit;
    logic [COUNT_BITS-1:0] cur_fault;
    logic [COUNT_BITS-1:0] cur_hit;

    assign cur_fault = i_req.clear ? '0 : r_fault;
    assign cur_hit   = i_req.clear ? '0 : r_hit;

    // hold at all ones once saturated
    assign n_fault = (!i_hit && !(&cur_fault)) ? cur_fault + COUNT_BITS'(1) : cur_fault;
    assign n_hit   = (i_hit && !(&cur_hit)) ? cur_hit + COUNT_BITS'(1) : cur_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
            r_hit   <= '0;
        end else if (i_req.go) begin
            r_fault <= n_fault;
            r_hit   <= n_hit;
        end
    end

    assign o_fault_total = n_fault;
    assign o_hit_total   = n_hit;

endmodule

[rtl/core/lru_page_replacement.sv]
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+------------------------------------
// in       | input     | i_in_valid / o_in_stall  | i_page, i_start_new
// out      | output    | o_out_valid / i_out_stall| o_hit, o_slot, o_evicted_valid,
//          |           |                          | o_evicted_page, o_frames_used,
//          |           |                          | o_fault_total, o_hit_total
// cfg      | input     | i_cfg_we                 | i_cfg_wdata (frame limit)
//
// One access per cycle sustained unless the output stalls; input register, then result register.
// The rate is set by the combinational lookup, victim pick and rank update on the
// frame registers between the input register and the result register.
// Reset is synchronous; frame contents need no clearing pass, only the fill count.
// A stalled output holds its result; the input register keeps one access meanwhile.

module lru_page_replacement #(
    parameter int MAX_FRAMES = lrp_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrp_pkg::PAGE_BITS_DEF,
    parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lrp_pkg::CFG_BITS-1:0]   i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [PAGE_BITS-1:0]           i_page,
    input  logic                           i_start_new,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_hit,
    output logic [SLOT_W-1:0]              o_slot,
    output logic                           o_evicted_valid,
    output logic [PAGE_BITS-1:0]           o_evicted_page,
    output logic [CNT_W-1:0]               o_frames_used,
    output logic [lrp_pkg::COUNT_BITS-1:0] o_fault_total,
    output logic [lrp_pkg::COUNT_BITS-1:0] o_hit_total
);
    import lrp_pkg::*;

    logic [CFG_BITS-1:0]   r_limit;
    logic [CNT_W-1:0]      eff_limit;

    logic                  r_in_vld;
    logic [PAGE_BITS-1:0]  r_in_page;
    logic                  r_in_start;

    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_evict;
    logic [PAGE_BITS-1:0]  r_out_evpage;
    logic [CNT_W-1:0]      r_out_used;
    logic [COUNT_BITS-1:0] r_out_fault;
    logic [COUNT_BITS-1:0] r_out_hits;

    logic                  out_ready;
    logic                  process;
    logic                  in_take;
    t_frm_req              req;
    t_frm_stat             stat;
    logic [SLOT_W-1:0]     slot;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [CNT_W-1:0]      used;
    logic [COUNT_BITS-1:0] fault_total;
    logic [COUNT_BITS-1:0] hit_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // zero acts as one, anything above the built frame count as that count
    always_comb begin
        priority if (r_limit == '0) begin
            eff_limit = CNT_W'(1);
        end else if (32'(r_limit) > 32'(MAX_FRAMES)) begin
            eff_limit = CNT_W'(MAX_FRAMES);
        end else begin
            eff_limit = CNT_W'(r_limit);
        end
    end

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign process    = r_in_vld && out_ready;
    assign o_in_stall = r_in_vld && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_take || (r_in_vld && !process);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_page  <= i_page;
            r_in_start <= i_start_new;
        end
    end

    assign req.go    = process;
    assign req.clear = r_in_start;

    lrp_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_frames (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_page       (r_in_page),
        .i_limit      (eff_limit),
        .o_stat       (stat),
        .o_slot       (slot),
        .o_evict_page (ev_page),
        .o_count      (used)
    );

    lrp_counters u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_hit         (stat.hit),
        .o_fault_total (fault_total),
        .o_hit_total   (hit_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= process;
        end
    end

    // advance the result register on each processed access, hold while stalled
    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_hit    <= stat.hit;
            r_out_slot   <= slot;
            r_out_evict  <= stat.evict;
            r_out_evpage <= ev_page;
            r_out_used   <= used;
            r_out_fault  <= fault_total;
            r_out_hits   <= hit_total;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_hit           = r_out_hit;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_evpage;
    assign o_frames_used   = r_out_used;
    assign o_fault_total   = r_out_fault;
    assign o_hit_total     = r_out_hits;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int FRAMES      = 8;
    localparam int DIR_ROWS    = 25;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 185;
    localparam int POOL_MAX    = 12;

    typedef struct packed {
        logic        hit;
        logic [2:0]  slot;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [3:0]  used;
        logic [31:0] faults;
        logic [31:0] hits;
    } t_access_result;

    typedef struct packed {
        logic           cfg_write;
        logic [3:0]     cfg_value;
        logic [15:0]    page;
        logic           restart;
        logic           known;
        t_access_result want;
    } t_access_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lrp_pkg::CFG_BITS-1:0]   i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [15:0]                    i_page;
    logic                           i_start_new;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_hit;
    logic [2:0]                     o_slot;
    logic                           o_evicted_valid;
    logic [15:0]                    o_evicted_page;
    logic [3:0]                     o_frames_used;
    logic [lrp_pkg::COUNT_BITS-1:0] o_fault_total;
    logic [lrp_pkg::COUNT_BITS-1:0] o_hit_total;

    // local copy of the frame store
    logic [15:0] frame_page[FRAMES];
    int          frame_rank[FRAMES];
    int          frames_held;
    logic [31:0] fault_count;
    logic [31:0] hit_count;
    logic [3:0]  frame_limit_reg;

    t_access_result pending_results[$];

    int  mismatch_count = 0;
    int  sent_count     = 0;
    int  checked_count  = 0;
    int  hits_seen      = 0;
    int  evicts_seen    = 0;
    int  restarts_sent  = 0;
    int  limits_used    = 0;
    bit  quiet_sender   = 1'b0;
    bit  stall_on       = 1'b1;
    int  stall_hold     = 0;
    int unsigned stall_roll;

    t_access_row dir_rows[DIR_ROWS] = '{
        // cfg   limit  page      restart known  hit slot  ev    ev_page  used  faults hits
        '{1'b0, 4'd0,  16'h0000, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 4'd1, 32'd1, 32'd0}},
        '{1'b0, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 4'd2, 32'd2, 32'd0}},
        '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 4'd2, 32'd2, 32'd1}},
        '{1'b0, 4'd0,  16'h1234, 1'b0, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 4'd3, 32'd3, 32'd1}},
        '{1'b0, 4'd0,  16'h5555, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b1, 16'hFFFF, 4'd3, 32'd4, 32'd1}},
        '{1'b0, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 4'd3, 32'd5, 32'd1}},
        '{1'b0, 4'd0,  16'h1234, 1'b0, 1'b1, '{1'b1, 3'd2, 1'b0, 16'h0000, 4'd3, 32'd5, 32'd2}},
        '{1'b0, 4'd0,  16'hAAAA, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 4'd1, 32'd1, 32'd0}},
        '{1'b0, 4'd0,  16'hAAAA, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 4'd1, 32'd1, 32'd1}},
        // a limit of zero behaves as one frame
        '{1'b1, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'hAAAA, 4'd1, 32'd2, 32'd1}},
        '{1'b0, 4'd0,  16'h0001, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 4'd1, 32'd3, 32'd1}},
        // a limit above the frame count behaves as all frames
        '{1'b1, 4'd15, 16'h0002, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 4'd1, 32'd1, 32'd0}},
        '{1'b0, 4'd0,  16'h0004, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0008, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0010, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0020, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0040, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0080, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0100, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h7FFF, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0010, 1'b0, 1'b0, '0},
        // shrink the limit with all frames still occupied
        '{1'b1, 4'd2,  16'h8000, 1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0004, 1'b0, 1'b0, '0},
        '{1'b1, 4'd8,  16'h4321, 1'b0, 1'b0, '0},
        '{1'b1, 4'd3,  16'h0000, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 4'd1, 32'd1, 32'd0}}
    };

    logic [3:0] phase_limits[NUM_PHASES] = '{
        4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd3, 4'd6, 4'd4
    };

    lru_page_replacement uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_page         (i_page),
        .i_start_new    (i_start_new),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_slot         (o_slot),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page (o_evicted_page),
        .o_frames_used  (o_frames_used),
        .o_fault_total  (o_fault_total),
        .o_hit_total    (o_hit_total)
    );

    always #5 i_clk = ~i_clk;

    function automatic int frames_allowed(input logic [3:0] limit);
        if (limit == 4'd0) begin
            return 1;
        end
        return (limit > FRAMES) ? FRAMES : int'(limit);
    endfunction

    // One access against the local frame store; returns the expected outcome.
    function automatic t_access_result lru_access(input logic [15:0] pg, input logic restart);
        t_access_result r;
        int  lim;
        int  idx;
        int  old_rank;
        int  i;
        bit  found;
        r = '0;
        if (restart) begin
            frames_held = 0;
            fault_count = '0;
            hit_count   = '0;
        end
        lim   = frames_allowed(frame_limit_reg);
        found = 1'b0;
        idx   = 0;
        for (i = 0; i < frames_held; i++) begin
            if (!found && frame_page[i] == pg) begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found) begin
            old_rank  = frame_rank[idx];
            hit_count = (hit_count == 32'hFFFF_FFFF) ? hit_count : hit_count + 1;
        end else begin
            fault_count = (fault_count == 32'hFFFF_FFFF) ? fault_count : fault_count + 1;
            if (frames_held < lim) begin
                idx             = frames_held;
                frame_page[idx] = pg;
                frames_held++;
                old_rank        = frames_held;
            end else begin
                // victim is the oldest of every occupied frame, even above the limit
                idx = 0;
                for (i = 1; i < frames_held; i++) begin
                    if (frame_rank[i] > frame_rank[idx]) begin
                        idx = i;
                    end
                end
                r.ev_valid      = 1'b1;
                r.ev_page       = frame_page[idx];
                frame_page[idx] = pg;
                old_rank        = frame_rank[idx];
            end
        end
        // age every frame that was more recent than the touched one
        for (i = 0; i < frames_held; i++) begin
            if (i != idx && frame_rank[i] < old_rank) begin
                frame_rank[i]++;
            end
        end
        frame_rank[idx] = 0;
        r.hit    = found;
        r.slot   = 3'(idx);
        r.used   = 4'(frames_held);
        r.faults = fault_count;
        r.hits   = hit_count;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        if (quiet_sender) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_access(input logic [15:0] pg, input logic restart, input logic known,
                               input t_access_result want);
        int gap;
        t_access_result model;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_page      <= pg;
        i_start_new <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model = lru_access(pg, restart);
        pending_results.insert(pending_results.size(), known ? want : model);
        sent_count++;
        if (restart) begin
            restarts_sent++;
        end
    endtask

    // Drop valid and hold until every outstanding result has been transferred.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [3:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        frame_limit_reg  = value;
        limits_used++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || !stall_on) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 55) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 4);
            end else if (stall_roll < 93) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(8, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_hit, o_slot, o_evicted_valid, o_evicted_page, o_frames_used,
                    o_fault_total, o_hit_total};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 20) begin
                    $display("%0t: result transfer with nothing expected: hit=%0d slot=%0d",
                             $time, got.hit, got.slot);
                end
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 20) begin
                        $display("%0t: expected hit=%0d slot=%0d ev=%0d/%h used=%0d f=%0d h=%0d",
                                 $time, want.hit, want.slot, want.ev_valid, want.ev_page,
                                 want.used, want.faults, want.hits);
                        $display("%0t:   actual hit=%0d slot=%0d ev=%0d/%h used=%0d f=%0d h=%0d",
                                 $time, got.hit, got.slot, got.ev_valid, got.ev_page,
                                 got.used, got.faults, got.hits);
                    end
                end
                if (got.hit === 1'b1) begin
                    hits_seen++;
                end
                if (got.ev_valid === 1'b1) begin
                    evicts_seen++;
                end
            end
        end
    end

    initial begin
        logic [15:0] page_pool[POOL_MAX];
        logic [15:0] pg;
        logic        restart;
        int          ph;
        int          n;
        int          k;
        int          pool_n;
        int unsigned roll;
        int unsigned pick;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_page      = '0;
        i_start_new = 1'b0;
        for (k = 0; k < FRAMES; k++) begin
            frame_page[k] = '0;
            frame_rank[k] = 0;
        end
        frames_held     = 0;
        fault_count     = '0;
        hit_count       = '0;
        frame_limit_reg = lrp_pkg::LIMIT_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_write) begin
                wait_idle();
                write_limit(dir_rows[r].cfg_value);
            end
            send_access(dir_rows[r].page, dir_rows[r].restart, dir_rows[r].known,
                        dir_rows[r].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_limit(phase_limits[ph]);
            quiet_sender = (ph == 2 || ph == 6);
            stall_on     = !(ph == 2 || ph == 5);
            // pool a little larger than the frame count to mix hits with evictions
            pool_n = frames_allowed(phase_limits[ph]) + $urandom_range(1, 4);
            for (k = 0; k < pool_n; k++) begin
                page_pool[k] = 16'($urandom);
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (n == 0) begin
                    restart = 1'($urandom_range(0, 1));
                end else begin
                    restart = (roll < 2);
                end
                if (roll >= 2 && roll < 4) begin
                    wait_idle();
                end
                if (roll >= 95) begin
                    page_pool[$urandom_range(0, pool_n - 1)] = 16'($urandom);
                end
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    pg = page_pool[$urandom_range(0, pool_n - 1)];
                end else if (pick < 95) begin
                    pg = 16'($urandom);
                end else begin
                    pg = pick[0] ? 16'hFFFF : 16'h0000;
                end
                send_access(pg, restart, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d page accesses under %0d frame-limit writes, %0d sequence restarts.",
                 sent_count, limits_used, restarts_sent);
        $display("Checked %0d results: %0d hits, %0d evictions.",
                 checked_count, hits_seen, evicts_seen);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("lru_page_replacement: match");
        end else begin
            $display("lru_page_replacement: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("lru_page_replacement: mismatch");
        $finish;
    end

endmodule
